// File: rtl/core/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths and types for the point-to-segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int DOT_W     = PROD_W + 1;
    localparam int LEN_W     = PROD_W;
    localparam int FRAC_W    = 16;
    localparam int T_W       = FRAC_W + 1;
    localparam int TPROD_W   = T_W + 1 + DIFF_W;
    localparam int FOOT_W    = COORD_W + 2;
    localparam int SQ_W      = 2 * FOOT_W;
    localparam int DSQ_W     = SQ_W;
    localparam int ROOT_W    = DSQ_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int DIST_W    = 17;
    localparam int DIV_STEPS = T_W;

    localparam logic [1:0] REGION_INTERIOR = 2'd0;
    localparam logic [1:0] REGION_START    = 2'd1;
    localparam logic [1:0] REGION_END      = 2'd2;
    localparam logic [1:0] REGION_DEGEN    = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [DIFF_W-1:0]  cx;
        logic signed [DIFF_W-1:0]  cy;
        logic [1:0]                region;
    } geo_t;

endpackage

// File: rtl/core/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Differences, products and sums: dot, squared length and early region.
// ----------------------------------------------------------------------------
module psd_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [psd_pkg::COORD_W-1:0]   point_x,
    input  logic signed [psd_pkg::COORD_W-1:0]   point_y,
    input  logic signed [psd_pkg::COORD_W-1:0]   start_x,
    input  logic signed [psd_pkg::COORD_W-1:0]   start_y,
    input  logic signed [psd_pkg::COORD_W-1:0]   end_x,
    input  logic signed [psd_pkg::COORD_W-1:0]   end_y,
    output logic                                 out_valid,
    output logic [psd_pkg::DOT_W-1:0]            out_dot,
    output logic [psd_pkg::LEN_W-1:0]            out_len,
    output psd_pkg::geo_t                        out_geo
);

    logic                                v1_reg, v2_reg, v3_reg;
    logic signed [psd_pkg::DIFF_W-1:0]   ax_reg, ay_reg;
    psd_pkg::geo_t                       g1_reg, g2_reg, g3_reg;
    logic signed [psd_pkg::PROD_W-1:0]   acx_reg, acy_reg, ccx_reg, ccy_reg;
    logic signed [psd_pkg::DOT_W-1:0]    dot_next;
    logic [psd_pkg::LEN_W-1:0]           len_next;
    logic [psd_pkg::DOT_W-1:0]           dot_reg;
    logic [psd_pkg::LEN_W-1:0]           len_reg;
    psd_pkg::geo_t                       g3_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb begin
        dot_next = psd_pkg::DOT_W'(acx_reg) + psd_pkg::DOT_W'(acy_reg);
        len_next = psd_pkg::LEN_W'(ccx_reg) + psd_pkg::LEN_W'(ccy_reg);
        g3_next  = g2_reg;
        if (len_next == '0) begin
            g3_next.region = psd_pkg::REGION_DEGEN;
        end else if (dot_next < 0) begin
            g3_next.region = psd_pkg::REGION_START;
        end else if (dot_next >= $signed({1'b0, len_next})) begin
            // quotient would not fit: well beyond the end
            if (dot_next >= $signed({len_next, 1'b0}))
                g3_next.region = psd_pkg::REGION_END;
            else
                g3_next.region = psd_pkg::REGION_INTERIOR;
        end else begin
            g3_next.region = psd_pkg::REGION_INTERIOR;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg        <= psd_pkg::DIFF_W'(point_x) - psd_pkg::DIFF_W'(start_x);
            ay_reg        <= psd_pkg::DIFF_W'(point_y) - psd_pkg::DIFF_W'(start_y);
            g1_reg.px     <= point_x;
            g1_reg.py     <= point_y;
            g1_reg.sx     <= start_x;
            g1_reg.sy     <= start_y;
            g1_reg.cx     <= psd_pkg::DIFF_W'(end_x) - psd_pkg::DIFF_W'(start_x);
            g1_reg.cy     <= psd_pkg::DIFF_W'(end_y) - psd_pkg::DIFF_W'(start_y);
            g1_reg.region <= psd_pkg::REGION_INTERIOR;
            acx_reg       <= ax_reg * g1_reg.cx;
            acy_reg       <= ay_reg * g1_reg.cy;
            ccx_reg       <= g1_reg.cx * g1_reg.cx;
            ccy_reg       <= g1_reg.cy * g1_reg.cy;
            g2_reg        <= g1_reg;
            dot_reg       <= dot_next;
            len_reg       <= len_next;
            g3_reg        <= g3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_dot   = dot_reg;
    assign out_len   = len_reg;
    assign out_geo   = g3_reg;

endmodule

// File: rtl/core/psd_div.sv
// ----------------------------------------------------------------------------
// psd_div
// Pipelined restoring divider: one quotient bit of dot*2^16/len per stage.
// ----------------------------------------------------------------------------
module psd_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [psd_pkg::DOT_W-1:0]     in_dot,
    input  logic [psd_pkg::LEN_W-1:0]     in_len,
    input  psd_pkg::geo_t                 in_geo,
    output logic                          out_valid,
    output logic [psd_pkg::T_W-1:0]       out_quot,
    output psd_pkg::geo_t                 out_geo
);

    localparam int N = psd_pkg::DIV_STEPS;

    logic                        v_reg [N];
    logic [psd_pkg::DOT_W-1:0]   r_reg [N];
    logic [psd_pkg::LEN_W-1:0]   d_reg [N];
    logic [psd_pkg::T_W-1:0]     q_reg [N];
    psd_pkg::geo_t               g_reg [N];

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_step
            logic [psd_pkg::DOT_W-1:0] r_in;
            logic [psd_pkg::LEN_W-1:0] d_in;
            logic [psd_pkg::T_W-1:0]   q_in;
            logic                      v_in;
            psd_pkg::geo_t             g_in;
            logic                      take;

            if (i == 0) begin : g_first
                assign r_in = in_dot;
                assign d_in = in_len;
                assign q_in = '0;
                assign v_in = in_valid;
                assign g_in = in_geo;
            end else begin : g_rest
                // remainder < len for 0 <= dot < 2*len: no shift overflow
                assign r_in = {r_reg[i-1][psd_pkg::DOT_W-2:0], 1'b0};
                assign d_in = d_reg[i-1];
                assign q_in = q_reg[i-1];
                assign v_in = v_reg[i-1];
                assign g_in = g_reg[i-1];
            end

            assign take = (r_in >= {1'b0, d_in});

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i] <= 1'b0;
                end else if (en) begin
                    v_reg[i] <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[i] <= take ? (r_in - {1'b0, d_in}) : r_in;
                    d_reg[i] <= d_in;
                    q_reg[i] <= {q_in[psd_pkg::T_W-2:0], take};
                    g_reg[i] <= g_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[N-1];
    assign out_quot  = q_reg[N-1];
    assign out_geo   = g_reg[N-1];

endmodule

// File: rtl/core/psd_back.sv
// ----------------------------------------------------------------------------
// psd_back
// Clamp the fraction, form the foot point and the squared distance.
// ----------------------------------------------------------------------------
module psd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [psd_pkg::T_W-1:0]       in_quot,
    input  psd_pkg::geo_t                 in_geo,
    output logic                          out_valid,
    output logic [psd_pkg::DSQ_W-1:0]     out_dsq,
    output logic [1:0]                    out_region
);

    localparam logic [psd_pkg::T_W-1:0] ONE = psd_pkg::T_W'(1) << psd_pkg::FRAC_W;

    logic                                 v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [psd_pkg::T_W-1:0]              t_reg;
    psd_pkg::geo_t                        g1_reg, g2_reg;
    psd_pkg::geo_t                        g1_next;
    logic signed [psd_pkg::TPROD_W-1:0]   tcx_reg, tcy_reg;
    logic signed [psd_pkg::FOOT_W-1:0]    dx_reg, dy_reg;
    logic signed [psd_pkg::FOOT_W-1:0]    fx_next, fy_next;
    logic signed [psd_pkg::SQ_W-1:0]      sqx_next, sqy_next;
    logic [psd_pkg::SQ_W-1:0]             sqx_reg, sqy_reg;
    logic [psd_pkg::DSQ_W-1:0]            dsq_reg;
    logic [1:0]                           r3_reg, r4_reg, r5_reg;
    logic [psd_pkg::T_W-1:0]              t_next;
    logic [1:0]                           region_next;

    always_comb begin
        region_next = in_geo.region;
        if (in_geo.region == psd_pkg::REGION_INTERIOR && in_quot > ONE)
            region_next = psd_pkg::REGION_END;
        // start/degenerate use t = 0, end uses t = 1: the same foot formula hits S or E
        case (region_next)
            psd_pkg::REGION_INTERIOR: t_next = in_quot;
            psd_pkg::REGION_END:      t_next = ONE;
            default:                  t_next = '0;
        endcase
        g1_next        = in_geo;
        g1_next.region = region_next;
    end

    always_comb begin
        fx_next = psd_pkg::FOOT_W'(g2_reg.sx) + psd_pkg::FOOT_W'(tcx_reg >>> psd_pkg::FRAC_W);
        fy_next = psd_pkg::FOOT_W'(g2_reg.sy) + psd_pkg::FOOT_W'(tcy_reg >>> psd_pkg::FRAC_W);
        sqx_next = dx_reg * dx_reg;
        sqy_next = dy_reg * dy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg         <= t_next;
            g1_reg        <= g1_next;
            tcx_reg       <= $signed({1'b0, t_reg}) * g1_reg.cx;
            tcy_reg       <= $signed({1'b0, t_reg}) * g1_reg.cy;
            g2_reg        <= g1_reg;
            dx_reg        <= psd_pkg::FOOT_W'(g2_reg.px) - fx_next;
            dy_reg        <= psd_pkg::FOOT_W'(g2_reg.py) - fy_next;
            r3_reg        <= g2_reg.region;
            sqx_reg       <= $unsigned(sqx_next);
            sqy_reg       <= $unsigned(sqy_next);
            r4_reg        <= r3_reg;
            dsq_reg       <= sqx_reg + sqy_reg;
            r5_reg        <= r4_reg;
        end
    end

    assign out_valid  = v5_reg;
    assign out_dsq    = dsq_reg;
    assign out_region = r5_reg;

endmodule

// File: rtl/core/psd_sqrt.sv
// ----------------------------------------------------------------------------
// psd_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module psd_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [psd_pkg::DSQ_W-1:0]     in_dsq,
    input  logic [1:0]                    in_region,
    output logic                          out_valid,
    output logic [psd_pkg::ROOT_W-1:0]    out_root,
    output logic [1:0]                    out_region
);

    localparam int N = psd_pkg::ROOT_W;

    logic                         v_reg    [N];
    logic [psd_pkg::DSQ_W-1:0]    n_reg    [N];
    logic [psd_pkg::REM_W-1:0]    rem_reg  [N];
    logic [psd_pkg::ROOT_W-1:0]   root_reg [N];
    logic [1:0]                   reg_reg  [N];

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_step
            logic [psd_pkg::DSQ_W-1:0]  n_in;
            logic [psd_pkg::REM_W-1:0]  rem_in;
            logic [psd_pkg::ROOT_W-1:0] root_in;
            logic                       v_in;
            logic [1:0]                 reg_in;
            logic [psd_pkg::REM_W-1:0]  rem_sh;
            logic [psd_pkg::REM_W-1:0]  trial;
            logic                       take;

            if (i == 0) begin : g_first
                assign n_in    = in_dsq;
                assign rem_in  = '0;
                assign root_in = '0;
                assign v_in    = in_valid;
                assign reg_in  = in_region;
            end else begin : g_rest
                assign n_in    = n_reg[i-1];
                assign rem_in  = rem_reg[i-1];
                assign root_in = root_reg[i-1];
                assign v_in    = v_reg[i-1];
                assign reg_in  = reg_reg[i-1];
            end

            assign rem_sh = {rem_in[psd_pkg::REM_W-3:0],
                             n_in[psd_pkg::DSQ_W-1:psd_pkg::DSQ_W-2]};
            assign trial  = {1'b0, root_in, 2'b01};
            assign take   = (rem_sh >= trial);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i] <= 1'b0;
                end else if (en) begin
                    v_reg[i] <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    n_reg[i]    <= {n_in[psd_pkg::DSQ_W-3:0], 2'b00};
                    rem_reg[i]  <= take ? (rem_sh - trial) : rem_sh;
                    root_reg[i] <= {root_in[psd_pkg::ROOT_W-2:0], take};
                    reg_reg[i]  <= reg_in;
                end
            end
        end
    endgenerate

    assign out_valid  = v_reg[N-1];
    assign out_root   = root_reg[N-1];
    assign out_region = reg_reg[N-1];

endmodule

// File: rtl/core/point_segment_distance.sv
// ----------------------------------------------------------------------------
// point_segment_distance
// Distance from a Q8.8 point to a Q8.8 line segment, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one transaction per query; tdata carries point, start and end
//   coordinates as signed Q8.8. m_axis: one transaction per query, in order;
//   tdata carries the floored distance (unsigned Q9.8), tuser the region
//   (interior, clamped to start, clamped to end, degenerate segment).
// Stages: differences, products and dot/length sums; 17 divider stages (one
//   quotient bit each); foot point and squared distance; 18 square-root
//   stages.
// Throughput: one query per cycle unless a held result stalls the pipeline.
//   Everything advances on one enable; results drain as new queries enter.
// Reset: aresetn (synchronous, active low) clears every stage valid bit;
//   data registers are not reset. No state is kept between queries.
// Stall: when m_tready is low with a result waiting, every stage holds,
//   s_tready drops, and nothing is lost or repeated. Bubbles in the
//   pipeline keep moving toward the output while it is empty.
// ----------------------------------------------------------------------------
module point_segment_distance (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] point_x, [31:16] point_y, [47:32] start_x,
    // [63:48] start_y, [79:64] end_x, [95:80] end_y
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [16:0] distance, [23:17] zero
    output logic [23:0] m_tdata,
    // [1:0] region
    output logic [1:0]  m_tuser
);

    logic                             en;
    logic                             f_valid, d_valid, b_valid, q_valid;
    logic [psd_pkg::DOT_W-1:0]        f_dot;
    logic [psd_pkg::LEN_W-1:0]        f_len;
    psd_pkg::geo_t                    f_geo, d_geo;
    logic [psd_pkg::T_W-1:0]          d_quot;
    logic [psd_pkg::DSQ_W-1:0]        b_dsq;
    logic [1:0]                       b_region, q_region;
    logic [psd_pkg::ROOT_W-1:0]       q_root;

    // advance everything unless a finished result is held by the receiver
    assign en       = !q_valid || m_tready;
    assign s_tready = en;

    psd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .point_x   (s_tdata[15:0]),
        .point_y   (s_tdata[31:16]),
        .start_x   (s_tdata[47:32]),
        .start_y   (s_tdata[63:48]),
        .end_x     (s_tdata[79:64]),
        .end_y     (s_tdata[95:80]),
        .out_valid (f_valid),
        .out_dot   (f_dot),
        .out_len   (f_len),
        .out_geo   (f_geo)
    );

    psd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_dot    (f_dot),
        .in_len    (f_len),
        .in_geo    (f_geo),
        .out_valid (d_valid),
        .out_quot  (d_quot),
        .out_geo   (d_geo)
    );

    psd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (d_valid),
        .in_quot    (d_quot),
        .in_geo     (d_geo),
        .out_valid  (b_valid),
        .out_dsq    (b_dsq),
        .out_region (b_region)
    );

    psd_sqrt u_sqrt (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (b_valid),
        .in_dsq     (b_dsq),
        .in_region  (b_region),
        .out_valid  (q_valid),
        .out_root   (q_root),
        .out_region (q_region)
    );

    // drop the top root bit: the distance field is 17 bits wide
    assign m_tvalid = q_valid;
    assign m_tdata  = {7'd0, q_root[psd_pkg::DIST_W-1:0]};
    assign m_tuser  = q_region;

endmodule

// File: tb/sv/point_segment_distance_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance_tb
// Streams point and segment queries through the distance pipeline and checks
// every result against a predictor of the floored distance and the region.
// ----------------------------------------------------------------------------
module point_segment_distance_tb;

    typedef struct packed {
        logic signed [15:0] ey;
        logic signed [15:0] ex;
        logic signed [15:0] sy;
        logic signed [15:0] sx;
        logic signed [15:0] py;
        logic signed [15:0] px;
    } query_t;

    typedef struct {
        logic [16:0] distance;
        logic [1:0]  region;
    } answer_t;

    typedef struct {
        query_t      q;
        logic        known;
        logic [16:0] distance;
        logic [1:0]  region;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    answer_t     pending_answers[$];
    int          errors;
    int          send_idle_pct;
    int          recv_idle_pct;

    point_segment_distance dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Integer square root, floored, by bit-pair restoring method.
    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Floor of v / 2^16 for signed v.
    function automatic longint floor_frac(longint v);
        return v >>> psd_pkg::FRAC_W;
    endfunction

    function automatic answer_t nearest_distance(query_t q);
        longint ax, ay, cx, cy, dp, lsq, fx, fy, dx, dy;
        longint unsigned t;
        answer_t a;
        ax  = longint'(q.px) - longint'(q.sx);
        ay  = longint'(q.py) - longint'(q.sy);
        cx  = longint'(q.ex) - longint'(q.sx);
        cy  = longint'(q.ey) - longint'(q.sy);
        dp  = ax * cx + ay * cy;
        lsq = cx * cx + cy * cy;
        if (lsq == 0) begin
            fx = q.sx; fy = q.sy; a.region = psd_pkg::REGION_DEGEN;
        end else if (dp < 0) begin
            fx = q.sx; fy = q.sy; a.region = psd_pkg::REGION_START;
        end else begin
            t = ($unsigned(dp) << psd_pkg::FRAC_W) / $unsigned(lsq);
            if (t > (64'd1 << psd_pkg::FRAC_W)) begin
                fx = q.ex; fy = q.ey; a.region = psd_pkg::REGION_END;
            end else begin
                fx = longint'(q.sx) + floor_frac(longint'(t) * cx);
                fy = longint'(q.sy) + floor_frac(longint'(t) * cy);
                a.region = psd_pkg::REGION_INTERIOR;
            end
        end
        dx = longint'(q.px) - fx;
        dy = longint'(q.py) - fy;
        a.distance = 17'(root_floor($unsigned(dx * dx) + $unsigned(dy * dy)));
        return a;
    endfunction

    function automatic query_t mk(int px, int py, int sx, int sy, int ex, int ey);
        query_t q;
        q.px = 16'(px); q.py = 16'(py); q.sx = 16'(sx);
        q.sy = 16'(sy); q.ex = 16'(ex); q.ey = 16'(ey);
        return q;
    endfunction

    function automatic logic [15:0] rand_coord(int span);
        if (span == 0) return 16'($urandom);
        return 16'($urandom_range(2 * span) - span);
    endfunction

    // Send one query; hold tvalid high across back-to-back transactions.
    task automatic send_query(query_t q);
        while (($urandom % 100) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= q;
        pending_answers.push_back(nearest_distance(q));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Receiver: randomize tready at the falling edge, check at the rising edge.
    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else          m_tready <= (($urandom % 100) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        answer_t exp_a;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                $error("result with no query outstanding: tdata %h", m_tdata);
                errors++;
            end else begin
                exp_a = pending_answers.pop_front();
                if (m_tdata[16:0] !== exp_a.distance) begin
                    $error("distance: expected %0d actual %0d", exp_a.distance, m_tdata[16:0]);
                    errors++;
                end
                if (m_tdata[23:17] !== 7'd0) begin
                    $error("pad: expected 0 actual %0d", m_tdata[23:17]);
                    errors++;
                end
                if (m_tuser !== exp_a.region) begin
                    $error("region: expected %0d actual %0d", exp_a.region, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        row_t   rows[$];
        row_t   r;
        query_t q;
        int     phase, n, span, kind, wait_cnt;
        answer_t a;

        errors = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table: expected values typed in only where obvious.
        rows.push_back('{mk(0, 0, 0, 0, 0, 0), 1, 17'd0, psd_pkg::REGION_DEGEN});
        rows.push_back('{mk(256, 0, 0, 0, 0, 0), 1, 17'd256, psd_pkg::REGION_DEGEN});
        rows.push_back('{mk(-256, 0, 0, 0, 256, 0), 1, 17'd256, psd_pkg::REGION_START});
        rows.push_back('{mk(512, 0, 0, 0, 256, 0), 1, 17'd256, psd_pkg::REGION_END});
        rows.push_back('{mk(128, 256, 0, 0, 256, 0), 1, 17'd256, psd_pkg::REGION_INTERIOR});
        rows.push_back('{mk(256, 0, 0, 0, 256, 0), 1, 17'd0, psd_pkg::REGION_INTERIOR});
        rows.push_back('{mk(-32768, -32768, 32767, 32767, 32767, 32767), 1,
                         17'd92680, psd_pkg::REGION_DEGEN});
        rows.push_back('{mk(32767, -32768, -32768, 32767, 32767, 32767), 0, 0, 0});
        rows.push_back('{mk(-32768, -32768, -32768, 32767, 32767, -32768), 0, 0, 0});
        rows.push_back('{mk(32767, 32767, -32768, -32768, 32767, 32767), 0, 0, 0});
        rows.push_back('{mk(-32768, 32767, 32767, -32768, -32768, 32767), 0, 0, 0});
        rows.push_back('{mk(0, 0, -32768, -32768, 32767, 32767), 0, 0, 0});
        rows.push_back('{mk(-1, -1, 0, 0, 3, 7), 0, 0, 0});
        rows.push_back('{mk(5, -9, 0, 0, 3, 7), 0, 0, 0});
        rows.push_back('{mk(100, 33, 1, -1, -2, 5), 0, 0, 0});
        rows.push_back('{mk(0, 0, 3, 0, 0, 3), 0, 0, 0});

        foreach (rows[i]) begin
            r = rows[i];
            if (r.known) begin
                a = nearest_distance(r.q);
                if (a.distance !== r.distance || a.region !== r.region) begin
                    $error("table row %0d: expected %0d/%0d predicted %0d/%0d",
                           i, r.distance, r.region, a.distance, a.region);
                    errors++;
                end
            end
            send_query(r.q);
        end

        // Random part in three idling phases.
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 72 : 0;
            recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 32 : 0;
            for (n = 0; n < 330; n++) begin
                kind = $urandom_range(3);
                span = (kind == 0) ? 0 : (kind == 1) ? 2048 : (kind == 2) ? 16 : 0;
                q.px = rand_coord(span); q.py = rand_coord(span);
                q.sx = rand_coord(span); q.sy = rand_coord(span);
                q.ex = rand_coord(span); q.ey = rand_coord(span);
                if (kind == 3 && ($urandom % 2)) begin
                    q.ex = q.sx; q.ey = q.sy;
                end
                send_query(q);
            end
        end
        s_tvalid <= 1'b0;

        wait_cnt = 0;
        while (pending_answers.size() != 0 && wait_cnt < 200000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (100) @(posedge aclk);
        if (errors == 0 && pending_answers.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            if (pending_answers.size() != 0)
                $error("%0d results never arrived", pending_answers.size());
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
